@@ rtl/core/pprc_pkg.sv @@
// pprc_pkg: shared types and constants of the prominent peak rate counter
// controller state codes, command and status bundles, result field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pprc_pkg;

	localparam int COUNT_W   = 10;
	localparam int RATE_W    = 22;
	localparam int RATE_Q8_W = 16;

	localparam logic [COUNT_W-1:0]   COUNT_MAX     = 10'd1023;
	localparam logic [RATE_W-1:0]    RATE_MAX      = 22'h3FFFFF;
	localparam logic [RATE_Q8_W-1:0] RATE_Q8_RESET = 16'd2560;
	localparam logic [7:0]           HALF_Q8       = 8'd128;

	// one state per analysis phase; the datapath keys its work off this code
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FIND,
		ST_MUL_NS2,
		ST_MUL_S1,
		ST_MUL_NN,
		ST_SEL,
		ST_PROM_L,
		ST_PROM_R,
		ST_MUL_PP,
		ST_MUL_PN,
		ST_TEST,
		ST_MUL_RATE,
		ST_DIV,
		ST_EMIT
	} pprc_state_t;

	typedef struct packed {
		pprc_state_t state;
		logic        load;
		logic        emit;
	} pprc_cmd_t;

	typedef struct packed {
		logic done;
		logic found;
		logic rate_go;
		logic out_busy;
	} pprc_status_t;

endpackage

`default_nettype wire

@@ rtl/core/prominent_peak_rate_counter.sv @@
// prominent_peak_rate_counter: top level, window of samples to peak count and rate
// depends on pprc_pkg, pprc_ctrl, pprc_dp (which holds two pprc_ram instances)
`timescale 1ns / 1ps
`default_nettype none

// Samples stream in one beat per cycle into a MAX_SAMPLES deep store while the
// running sum and sum of squares are kept; a beat with last_sample closes the
// window (samples past capacity are dropped and reported in truncated). The
// input then stalls while the analysis runs: one pass over the n stored samples
// finds the local maxima (flat tops at their midpoint), a few shift-add
// multiplies, one step per bit of the second operand, form the spread term,
// then for every peak kept by the distance rule one pass over the peak list
// thins and ranks, a left and right walk over the sample store measures its
// prominence, and two more multiplies test it against 0.3 sigma. A final
// multiply and a bitwise restoring divide give the Q14.8 per minute rate.
// Analysis time is set by the single read port of the sample memory and the
// one shared multiplier. One result beat per window waits in an output
// register, so loading of the next window may start while it is still
// stalled. The user must write the rate register rate_q over the cfg channel
// only between windows; the block itself does not enforce this.
module prominent_peak_rate_counter #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// sample channel
	input  wire logic                           sample_valid,
	output logic                                sample_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]  sample,
	input  wire logic                           last_sample,
	// configuration channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pprc_pkg::RATE_Q8_W-1:0] cfg_data,
	// result channel
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic [pprc_pkg::COUNT_W-1:0]        peak_count,
	output logic [pprc_pkg::RATE_W-1:0]         rate_bpm,
	output logic                                rate_valid,
	output logic                                truncated
);
	import pprc_pkg::*;

	pprc_cmd_t    cmd;
	pprc_status_t status;

	// phase sequencing
	pprc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.last_sample  (last_sample),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// storage, scans and arithmetic
	pprc_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.peak_count   (peak_count),
		.rate_bpm     (rate_bpm),
		.rate_valid   (rate_valid),
		.truncated    (truncated)
	);

endmodule

`default_nettype wire

@@ rtl/core/pprc_ram.sv @@
// pprc_ram: generic single write port, single read port memory
// registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pprc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/pprc_ctrl.sv @@
// pprc_ctrl: phase sequencer of the peak rate counter
// depends on pprc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pprc_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    sample_valid,
	input  wire logic                    last_sample,
	output logic                         sample_stall,
	input  wire pprc_pkg::pprc_status_t  status,
	output pprc_pkg::pprc_cmd_t          cmd
);
	import pprc_pkg::*;

	pprc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.state    = state_q;
		cmd.load     = 1'b0;
		cmd.emit     = 1'b0;
		sample_stall = (state_q != ST_LOAD);
		unique case (state_q)
			ST_LOAD: begin
				cmd.load = sample_valid;
				if (sample_valid && last_sample) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				if (status.done) state_d = ST_MUL_NS2;
			end
			ST_MUL_NS2: begin
				if (status.done) state_d = ST_MUL_S1;
			end
			ST_MUL_S1: begin
				if (status.done) state_d = ST_MUL_NN;
			end
			ST_MUL_NN: begin
				if (status.done) state_d = ST_SEL;
			end
			ST_SEL: begin
				if (status.done) begin
					if (status.found) begin
						state_d = ST_PROM_L;
					end else if (status.rate_go) begin
						state_d = ST_MUL_RATE;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_PROM_L: begin
				if (status.done) state_d = ST_PROM_R;
			end
			ST_PROM_R: begin
				if (status.done) state_d = ST_MUL_PP;
			end
			ST_MUL_PP: begin
				if (status.done) state_d = ST_MUL_PN;
			end
			ST_MUL_PN: begin
				if (status.done) state_d = ST_TEST;
			end
			ST_TEST: begin
				state_d = ST_SEL;
			end
			ST_MUL_RATE: begin
				if (status.done) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/pprc_dp.sv @@
// pprc_dp: sample and peak memories, scan engines, shift-add multiplier,
// restoring divider and result register of the peak rate counter
// depends on pprc_pkg and pprc_ram
`timescale 1ns / 1ps
`default_nettype none

module pprc_dp #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pprc_pkg::pprc_cmd_t                 cmd,
	output pprc_pkg::pprc_status_t                   status,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pprc_pkg::RATE_Q8_W-1:0]      cfg_data,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic [pprc_pkg::COUNT_W-1:0]             peak_count,
	output logic [pprc_pkg::RATE_W-1:0]              rate_bpm,
	output logic                                     rate_valid,
	output logic                                     truncated
);
	import pprc_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int PD    = MAX_SAMPLES / 2;
	localparam int PAW   = $clog2(PD);
	localparam int PCW   = $clog2(PD + 1);
	localparam int SUM_W = SB + CW;
	localparam int SQ_W  = 2 * SB + CW;
	localparam int CMP_W = 2 * SB + 2 * CW + 8;
	localparam int MB_A  = (SUM_W > 2 * CW) ? SUM_W : 2 * CW;
	localparam int MB_W  = (MB_A > RATE_Q8_W) ? MB_A : RATE_Q8_W;
	localparam int NUM_W = CW + RATE_Q8_W + 6;
	localparam int DCW   = $clog2(NUM_W + 1);
	localparam int PE_W  = 1 + SB + AW;
	localparam int DW    = RATE_Q8_W - 8 + 1;
	localparam int DXW   = (AW > DW) ? AW : DW;
	localparam int CXW   = (CW > COUNT_W) ? CW : COUNT_W;

	pprc_state_t st_q;
	logic        first;
	assign first = (cmd.state != st_q);

	// configuration and window state
	logic [RATE_Q8_W-1:0]    rate_q;
	logic [DW-1:0]           dist_q;
	logic [CW-1:0]           fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sumsq_q;
	logic                    ovf_q;
	logic [2*SB-1:0]         sq_s1;
	logic                    sqv_s1;

	// scans
	logic [CW-1:0]        scan_q;
	logic [CW-1:0]        idx_s1;
	logic                 v_s1;
	logic signed [SB-1:0] prev_q;
	logic                 act_q;
	logic [CW-1:0]        start_q;
	logic [PCW-1:0]       np_q;
	logic [PCW-1:0]       pidx_q;
	logic [PAW-1:0]       pidx_s1;
	logic                 have_best_q;
	logic [AW-1:0]        best_pos_q;
	logic signed [SB-1:0] best_h_q;
	logic                 nb_found_q;
	logic [AW-1:0]        nb_pos_q;
	logic signed [SB-1:0] nb_h_q;
	logic signed [SB-1:0] lmin_q, rmin_q;
	logic                 stop_q;

	// arithmetic
	logic [CMP_W-1:0] mul_a_q, mul_p_q;
	logic [MB_W-1:0]  mul_b_q;
	logic [CMP_W-1:0] ns2_q, spread_q, rhs_q, lhs_q;
	logic [2*CW-1:0]  nn_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    first_q, last_q;
	logic [NUM_W-1:0] num_q, quo_q;
	logic [CW-1:0]    rem_q;
	logic [DCW-1:0]   dcnt_q;

	// result register
	logic                rv_q;
	logic [COUNT_W-1:0]  cnt_out_q;
	logic [RATE_W-1:0]   rate_out_q;
	logic                rvalid_out_q;
	logic                trunc_out_q;

	// memories
	logic                 s_we;
	logic [AW-1:0]        s_raddr;
	logic [SB-1:0]        s_rdata;
	logic                 p_we;
	logic [PAW-1:0]       p_waddr;
	logic [PE_W-1:0]      p_wdata;
	logic [PE_W-1:0]      p_rdata;

	pprc_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_sample_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (sample),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	pprc_ram #(.WIDTH(PE_W), .DEPTH(PD)) u_peak_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (pidx_q[PAW-1:0]),
		.rdata (p_rdata)
	);

	// load side
	logic          ld_ok;
	logic [SB-1:0] mag;
	assign ld_ok     = cmd.load && (fill_q < CW'(MAX_SAMPLES));
	assign s_we      = ld_ok;
	assign mag       = sample[SB-1] ? (~sample + SB'(1)) : sample;
	assign cfg_ready = 1'b1;

	// sample scan issue
	logic          s_issue;
	logic [CW-1:0] scan_m1;
	assign scan_m1 = scan_q - CW'(1);

	always_comb begin
		s_raddr = scan_q[AW-1:0];
		s_issue = 1'b0;
		case (cmd.state)
			ST_FIND:   s_issue = !first && (scan_q < fill_q);
			ST_PROM_L: begin
				s_raddr = scan_m1[AW-1:0];
				s_issue = !first && !stop_q && (scan_q != '0);
			end
			ST_PROM_R: s_issue = !first && !stop_q && (scan_q < fill_q);
			default:   s_issue = 1'b0;
		endcase
	end

	logic signed [SB-1:0] rd;
	assign rd = s_rdata;

	// local maximum found: flat top reported at floor of its midpoint
	logic          pk_emit;
	logic [CW:0]   pk_sum;
	assign pk_emit = (cmd.state == ST_FIND) && !first && v_s1 && (idx_s1 != '0)
		&& (rd < prev_q) && act_q;
	assign pk_sum  = {1'b0, start_q} + {1'b0, idx_s1} - (CW + 1)'(1);

	// peak list scan: thin around current best, pick next best
	logic                 p_issue;
	logic                 e_done;
	logic signed [SB-1:0] e_h;
	logic [AW-1:0]        e_pos;
	logic [AW-1:0]        e_diff;
	logic                 sel_v, sel_kill, better;
	assign p_issue  = (cmd.state == ST_SEL) && !first && (pidx_q < np_q);
	assign e_done   = p_rdata[PE_W-1];
	assign e_h      = p_rdata[PE_W-2:AW];
	assign e_pos    = p_rdata[AW-1:0];
	assign e_diff   = (e_pos > best_pos_q) ? (e_pos - best_pos_q) : (best_pos_q - e_pos);
	assign sel_v    = (cmd.state == ST_SEL) && !first && v_s1 && !e_done;
	assign sel_kill = sel_v && have_best_q && (DXW'(e_diff) < DXW'(dist_q));
	assign better   = !nb_found_q || (e_h > nb_h_q) || ((e_h == nb_h_q) && (e_pos > nb_pos_q));

	always_comb begin
		p_we    = 1'b0;
		p_waddr = pidx_s1;
		p_wdata = {1'b1, e_h, e_pos};
		if (pk_emit) begin
			p_we    = 1'b1;
			p_waddr = np_q[PAW-1:0];
			p_wdata = {1'b0, prev_q, pk_sum[AW:1]};
		end else if (sel_kill) begin
			p_we = 1'b1;
		end
	end

	// minimum peak spacing, half way rounds to even, at least one
	logic [7:0]    rq_frac;
	logic [DW-1:0] dist_raw;
	logic          dist_up;
	assign rq_frac  = rate_q[7:0];
	assign dist_up  = (rq_frac > HALF_Q8) || ((rq_frac == HALF_Q8) && rate_q[8]);
	assign dist_raw = DW'(rate_q[RATE_Q8_W-1:8]) + DW'(dist_up);

	// prominence from higher of the two bases
	logic signed [SB-1:0] base_hi;
	logic signed [SB:0]   pdiff;
	assign base_hi = (lmin_q > rmin_q) ? lmin_q : rmin_q;
	assign pdiff   = {best_h_q[SB-1], best_h_q} - {base_hi[SB-1], base_hi};

	logic [SUM_W-1:0] sabs;
	assign sabs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// divider step
	logic [CW:0] den, rn;
	assign den = (CW + 1)'(last_q - first_q);
	assign rn  = {rem_q, quo_q[NUM_W-1]};

	logic mul_done;
	assign mul_done = !first && (mul_b_q == '0);

	logic [CXW-1:0] cnt_x;
	assign cnt_x = CXW'(count_q);

	always_comb begin
		status.found    = nb_found_q;
		status.rate_go  = (count_q >= CW'(2));
		status.out_busy = rv_q && result_stall;
		case (cmd.state)
			ST_FIND:     status.done = !first && !v_s1 && (scan_q >= fill_q);
			ST_MUL_NS2,
			ST_MUL_S1,
			ST_MUL_NN,
			ST_MUL_PP,
			ST_MUL_PN,
			ST_MUL_RATE: status.done = mul_done;
			ST_SEL:      status.done = !first && !v_s1 && (pidx_q >= np_q);
			ST_PROM_L:   status.done = !first && !v_s1 && (stop_q || (scan_q == '0));
			ST_PROM_R:   status.done = !first && !v_s1 && (stop_q || (scan_q >= fill_q));
			ST_TEST:     status.done = 1'b1;
			ST_DIV:      status.done = !first && (dcnt_q == '0);
			default:     status.done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_LOAD;
			rate_q      <= RATE_Q8_RESET;
			dist_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			sumsq_q     <= '0;
			ovf_q       <= 1'b0;
			sq_s1       <= '0;
			sqv_s1      <= 1'b0;
			scan_q      <= '0;
			idx_s1      <= '0;
			v_s1        <= 1'b0;
			prev_q      <= '0;
			act_q       <= 1'b0;
			start_q     <= '0;
			np_q        <= '0;
			pidx_q      <= '0;
			pidx_s1     <= '0;
			have_best_q <= 1'b0;
			best_pos_q  <= '0;
			best_h_q    <= '0;
			nb_found_q  <= 1'b0;
			nb_pos_q    <= '0;
			nb_h_q      <= '0;
			lmin_q      <= '0;
			rmin_q      <= '0;
			stop_q      <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			mul_p_q     <= '0;
			ns2_q       <= '0;
			spread_q    <= '0;
			rhs_q       <= '0;
			lhs_q       <= '0;
			nn_q        <= '0;
			count_q     <= '0;
			first_q     <= '0;
			last_q      <= '0;
			num_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
		end else begin
			st_q <= cmd.state;

			if (cfg_valid && cfg_ready) begin
				rate_q <= cfg_data;
			end

			// window load with one stage of squaring before accumulation
			sqv_s1 <= ld_ok;
			sq_s1  <= mag * mag;
			if (sqv_s1) begin
				sumsq_q <= sumsq_q + SQ_W'(sq_s1);
			end
			if (ld_ok) begin
				fill_q <= fill_q + CW'(1);
				sum_q  <= sum_q + SUM_W'(sample);
			end else if (cmd.load) begin
				ovf_q <= 1'b1;
			end

			// read pipeline shared by all scans
			v_s1 <= !first && (s_issue || p_issue);

			// shift-add multiplier
			if (!first && (mul_b_q != '0)) begin
				if (mul_b_q[0]) begin
					mul_p_q <= mul_p_q + mul_a_q;
				end
				mul_a_q <= mul_a_q << 1;
				mul_b_q <= mul_b_q >> 1;
			end

			case (cmd.state)
				ST_FIND: begin
					if (first) begin
						scan_q      <= '0;
						np_q        <= '0;
						act_q       <= 1'b0;
						have_best_q <= 1'b0;
						count_q     <= '0;
						dist_q      <= (dist_raw == '0) ? DW'(1) : dist_raw;
					end else begin
						if (s_issue) begin
							idx_s1 <= scan_q;
							scan_q <= scan_q + CW'(1);
						end
						if (v_s1) begin
							prev_q <= rd;
							if (idx_s1 == '0) begin
								act_q <= 1'b0;
							end else if (rd > prev_q) begin
								start_q <= idx_s1;
								act_q   <= 1'b1;
							end else if (rd < prev_q) begin
								act_q <= 1'b0;
							end
							if (pk_emit) begin
								np_q <= np_q + PCW'(1);
							end
						end
					end
				end
				ST_MUL_NS2: begin
					if (first) begin
						mul_a_q <= CMP_W'(sumsq_q);
						mul_b_q <= MB_W'(fill_q);
						mul_p_q <= '0;
					end else if (mul_done) begin
						ns2_q <= mul_p_q;
					end
				end
				ST_MUL_S1: begin
					if (first) begin
						mul_a_q <= CMP_W'(sabs);
						mul_b_q <= MB_W'(sabs);
						mul_p_q <= '0;
					end else if (mul_done) begin
						spread_q <= ns2_q - mul_p_q;
					end
				end
				ST_MUL_NN: begin
					if (first) begin
						mul_a_q <= CMP_W'(fill_q);
						mul_b_q <= MB_W'(fill_q);
						mul_p_q <= '0;
					end else if (mul_done) begin
						nn_q  <= mul_p_q[2*CW-1:0];
						rhs_q <= (spread_q << 3) + spread_q;
					end
				end
				ST_SEL: begin
					if (first) begin
						pidx_q     <= '0;
						nb_found_q <= 1'b0;
					end else begin
						if (p_issue) begin
							pidx_s1 <= pidx_q[PAW-1:0];
							pidx_q  <= pidx_q + PCW'(1);
						end
						if (sel_v && !sel_kill && better) begin
							nb_found_q <= 1'b1;
							nb_pos_q   <= e_pos;
							nb_h_q     <= e_h;
						end
						if (status.done && nb_found_q) begin
							have_best_q <= 1'b1;
							best_pos_q  <= nb_pos_q;
							best_h_q    <= nb_h_q;
						end
					end
				end
				ST_PROM_L: begin
					if (first) begin
						scan_q <= CW'(best_pos_q);
						lmin_q <= best_h_q;
						stop_q <= 1'b0;
					end else begin
						if (s_issue) begin
							scan_q <= scan_m1;
						end
						if (v_s1 && !stop_q) begin
							if (rd > best_h_q) begin
								stop_q <= 1'b1;
							end else if (rd < lmin_q) begin
								lmin_q <= rd;
							end
						end
					end
				end
				ST_PROM_R: begin
					if (first) begin
						scan_q <= CW'(best_pos_q) + CW'(1);
						rmin_q <= best_h_q;
						stop_q <= 1'b0;
					end else begin
						if (s_issue) begin
							scan_q <= scan_q + CW'(1);
						end
						if (v_s1 && !stop_q) begin
							if (rd > best_h_q) begin
								stop_q <= 1'b1;
							end else if (rd < rmin_q) begin
								rmin_q <= rd;
							end
						end
					end
				end
				ST_MUL_PP: begin
					if (first) begin
						mul_a_q <= CMP_W'(pdiff[SB-1:0]);
						mul_b_q <= MB_W'(pdiff[SB-1:0]);
						mul_p_q <= '0;
					end
				end
				ST_MUL_PN: begin
					if (first) begin
						mul_a_q <= mul_p_q;
						mul_b_q <= MB_W'(nn_q);
						mul_p_q <= '0;
					end else if (mul_done) begin
						lhs_q <= (mul_p_q << 6) + (mul_p_q << 5) + (mul_p_q << 2);
					end
				end
				ST_TEST: begin
					if (lhs_q >= rhs_q) begin
						count_q <= count_q + CW'(1);
						if ((count_q == '0) || (best_pos_q < first_q)) first_q <= best_pos_q;
						if ((count_q == '0) || (best_pos_q > last_q)) last_q <= best_pos_q;
					end
				end
				ST_MUL_RATE: begin
					if (first) begin
						mul_a_q <= CMP_W'(count_q - CW'(1));
						mul_b_q <= MB_W'(rate_q);
						mul_p_q <= '0;
					end else if (mul_done) begin
						num_q <= NUM_W'((mul_p_q << 6) - (mul_p_q << 2));
					end
				end
				ST_DIV: begin
					if (first) begin
						quo_q  <= num_q;
						rem_q  <= '0;
						dcnt_q <= DCW'(NUM_W);
					end else if (dcnt_q != '0) begin
						dcnt_q <= dcnt_q - DCW'(1);
						if (rn >= den) begin
							rem_q <= CW'(rn - den);
							quo_q <= {quo_q[NUM_W-2:0], 1'b1};
						end else begin
							rem_q <= rn[CW-1:0];
							quo_q <= {quo_q[NUM_W-2:0], 1'b0};
						end
					end
				end
				default: begin
				end
			endcase

			// result taken into the output register clears the window
			if (cmd.emit) begin
				fill_q  <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q         <= 1'b0;
			cnt_out_q    <= '0;
			rate_out_q   <= '0;
			rvalid_out_q <= 1'b0;
			trunc_out_q  <= 1'b0;
		end else if (cmd.emit) begin
			rv_q         <= 1'b1;
			cnt_out_q    <= (cnt_x > CXW'(COUNT_MAX)) ? COUNT_MAX : cnt_x[COUNT_W-1:0];
			rvalid_out_q <= status.rate_go;
			trunc_out_q  <= ovf_q;
			if (!status.rate_go) begin
				rate_out_q <= '0;
			end else if (quo_q > NUM_W'(RATE_MAX)) begin
				rate_out_q <= RATE_MAX;
			end else begin
				rate_out_q <= quo_q[RATE_W-1:0];
			end
		end else if (!result_stall) begin
			rv_q <= 1'b0;
		end
	end

	assign result_valid = rv_q;
	assign peak_count   = cnt_out_q;
	assign rate_bpm     = rate_out_q;
	assign rate_valid   = rvalid_out_q;
	assign truncated    = trunc_out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_SAMPLES))
		else $error("window fill beyond capacity");

	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		np_q <= PCW'(PD))
		else $error("peak list beyond capacity");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && status.rate_go) |-> (first_q < last_q))
		else $error("rate span is empty with two or more counted peaks");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.state == ST_DIV && !first) |-> ((CW + 1)'(rem_q) < den))
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking testbench of prominent_peak_rate_counter
// depends on pprc_pkg and the block's rtl; windows of samples in, one result per window
`timescale 1ns / 1ps

module tb;
	import pprc_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int PK_DEPTH   = DEPTH / 2 + 1;
	localparam int IDLE_LIMIT = 300000;
	localparam int ITEM_GOAL  = 1900;

	typedef struct {
		logic signed [23:0] s;
		logic               last;
	} sample_beat_t;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic [RATE_W-1:0]  rate;
		logic               rvalid;
		logic               trunc;
	} peak_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	logic signed [23:0]     sample = '0;
	logic                   last_sample = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [RATE_Q8_W-1:0]   cfg_data = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [COUNT_W-1:0]     peak_count;
	logic [RATE_W-1:0]      rate_bpm;
	logic                   rate_valid;
	logic                   truncated;

	prominent_peak_rate_counter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.last_sample (last_sample),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.peak_count  (peak_count),
		.rate_bpm    (rate_bpm),
		.rate_valid  (rate_valid),
		.truncated   (truncated)
	);

	// ---------------------------------------------------------------
	// predictor state: window store, running sums, rate register
	// ---------------------------------------------------------------
	int                   win_store [DEPTH];
	int                   win_fill = 0;
	longint               win_sum = 0;
	logic [127:0]         win_sq_sum = '0;
	bit                   win_dropped = 1'b0;
	logic [RATE_Q8_W-1:0] rate_q8 = RATE_Q8_RESET;
	int                   pk_pos [PK_DEPTH];
	bit                   pk_keep [PK_DEPTH];

	peak_report_t report_q [$];
	sample_beat_t pending_q [$];

	int  mismatches = 0;
	int  windows_sent = 0;
	int  reports_seen = 0;
	int  items_sent = 0;
	bit  want_hold = 1'b0;
	bit  hold_done = 1'b0;
	logic sample_taken = 1'b0;
	logic any_taken = 1'b0;

	// height first, then larger position
	function automatic bit outranks(int pa, int pb);
		if (win_store[pa] != win_store[pb])
			return win_store[pa] > win_store[pb];
		return pa > pb;
	endfunction

	function automatic longint unsigned prom_height(int n, int k);
		longint top, lft, rgt;
		top = win_store[k];
		lft = top;
		rgt = top;
		for (int i = k - 1; i >= 0; i--) begin
			if (win_store[i] > top)
				break;
			if (win_store[i] < lft)
				lft = win_store[i];
		end
		for (int i = k + 1; i < n; i++) begin
			if (win_store[i] > top)
				break;
			if (win_store[i] < rgt)
				rgt = win_store[i];
		end
		return top - (lft > rgt ? lft : rgt);
	endfunction

	// analysis of the closed window
	function automatic peak_report_t analyze_window();
		peak_report_t          r;
		int                    n, np, min_gap, fin, p, j, k, cnt, first, last;
		logic [127:0]          sabs, spread, rhs, lhs, pr;
		longint unsigned       rate;
		n = win_fill;
		np = 0;
		// local maxima, flat tops reported at the floor of their midpoint
		for (int i = 1; i + 1 < n; i++) begin
			if (win_store[i] > win_store[i-1]) begin
				fin = i;
				while (fin + 1 < n && win_store[fin+1] == win_store[i])
					fin++;
				if (fin + 1 < n && win_store[fin] > win_store[fin+1] && np < PK_DEPTH) begin
					pk_pos[np] = (i + fin) / 2;
					pk_keep[np] = 1'b1;
					np++;
				end
				i = fin;
			end
		end
		// minimum spacing, half rounds to even, never below one
		min_gap = (int'(rate_q8) + 128) >> 8;
		if (rate_q8[7:0] == HALF_Q8 && !rate_q8[8])
			min_gap = rate_q8 >> 8;
		if (min_gap < 1)
			min_gap = 1;
		for (int i = 1; i < np; i++) begin
			p = pk_pos[i];
			j = i;
			while (j > 0 && outranks(p, pk_pos[j-1])) begin
				pk_pos[j] = pk_pos[j-1];
				j--;
			end
			pk_pos[j] = p;
		end
		for (int i = 0; i < np; i++) begin
			if (pk_keep[i]) begin
				for (int m = i + 1; m < np; m++) begin
					if ((pk_pos[i] > pk_pos[m] ? pk_pos[i] - pk_pos[m]
						: pk_pos[m] - pk_pos[i]) < min_gap)
						pk_keep[m] = 1'b0;
				end
			end
		end
		// prominence against 0.3 sigma, squared and scaled to integers
		sabs = win_sum < 0 ? -win_sum : win_sum;
		spread = win_sq_sum * n - sabs * sabs;
		rhs = spread * 9;
		cnt = 0;
		first = 0;
		last = 0;
		for (int i = 0; i < np; i++) begin
			if (pk_keep[i]) begin
				k = pk_pos[i];
				pr = prom_height(n, k);
				lhs = pr * pr * n * n * 100;
				if (lhs >= rhs) begin
					if (cnt == 0 || k < first)
						first = k;
					if (cnt == 0 || k > last)
						last = k;
					cnt++;
				end
			end
		end
		r.rvalid = cnt >= 2 && last > first;
		rate = 0;
		if (r.rvalid) begin
			rate = longint'(cnt - 1) * rate_q8 * 60 / (last - first);
			if (rate > RATE_MAX)
				rate = RATE_MAX;
		end
		r.count = cnt > COUNT_MAX ? COUNT_MAX : COUNT_W'(cnt);
		r.rate = RATE_W'(rate);
		r.trunc = win_dropped;
		return r;
	endfunction

	// one accepted sample beat into the predictor
	function automatic void take_sample(sample_beat_t b);
		int sv;
		sv = b.s;
		if (win_fill < DEPTH) begin
			win_store[win_fill] = sv;
			win_fill++;
			win_sum += sv;
			win_sq_sum += 128'(longint'(sv) * longint'(sv));
		end else begin
			win_dropped = 1'b1;
		end
		if (b.last) begin
			report_q.push_back(analyze_window());
			win_fill = 0;
			win_sum = 0;
			win_sq_sum = '0;
			win_dropped = 1'b0;
		end
	endfunction

	// ---------------------------------------------------------------
	// clock and reset
	// ---------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ---------------------------------------------------------------
	// monitor: accepted beats at the rising edge feed the predictor,
	// result beats are checked against the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		sample_beat_t b;
		peak_report_t e;
		if (arst_n) begin
			sample_taken <= sample_valid && !sample_stall;
			any_taken <= (sample_valid && !sample_stall) || (cfg_valid && cfg_ready)
				|| (result_valid && !result_stall);
			if (sample_valid && !sample_stall) begin
				b.s = sample;
				b.last = last_sample;
				take_sample(b);
			end
			if (result_valid && !result_stall) begin
				reports_seen++;
				if (report_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] result beat with nothing expected", $realtime);
				end else begin
					e = report_q.pop_front();
					if (peak_count !== e.count || rate_bpm !== e.rate
						|| rate_valid !== e.rvalid || truncated !== e.trunc) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"[%0t] mismatch exp/act: count %0d/%0d",
								" rate %0d/%0d valid %0b/%0b trunc %0b/%0b"},
								$realtime, e.count, peak_count, e.rate, rate_bpm,
								e.rvalid, rate_valid, e.trunc, truncated);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// sample driver: bursts of random length, random gaps between them
	// ---------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		sample_beat_t b;
		if (arst_n && (!sample_valid || sample_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				sample_valid <= 1'b0;
			end else if (pending_q.size() == 0) begin
				sample_valid <= 1'b0;
			end else begin
				b = pending_q.pop_front();
				sample <= b.s;
				last_sample <= b.last;
				sample_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					// a new burst, sometimes a long one; sometimes no gap at all
					burst_left <= $urandom_range(0, 3) == 0 ? $urandom_range(40, 200)
						: $urandom_range(1, 12);
					gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result receiver: stall pattern picked at random from three modes, plus one
	// long hold-off so the block fills up and stalls its input
	// ---------------------------------------------------------------
	int rx_cycle = 0;
	int rx_mode = 0;
	int hold_left = 0;

	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0)
			rx_mode <= $urandom_range(0, 2);
		if (want_hold && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 600;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			case (rx_mode)
				0: begin
					result_stall <= 1'b0;
				end
				1: begin
					result_stall <= $urandom_range(0, 3) == 0;
				end
				default: begin
					result_stall <= $urandom_range(0, 9) < 7;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// watchdog: cycles with no beat on any channel
	// ---------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (any_taken)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	function automatic void push_beat(int v, bit last);
		sample_beat_t b;
		b.s = 24'(v);
		b.last = last;
		pending_q.push_back(b);
		items_sent++;
	endfunction

	// a window of n samples; kind picks the shape of its content
	function automatic void push_window(int n, int kind);
		int period, amp, v, ph, noise;
		period = $urandom_range(3, 12);
		amp = $urandom_range(1, 3000000);
		noise = $urandom_range(0, amp / 4);
		ph = $urandom_range(0, period - 1);
		for (int i = 0; i < n; i++) begin
			case (kind)
				0: v = $urandom;                        // full range noise, every bit toggles
				1: v = $signed(24'($urandom_range(0, 15))) - 8;   // tiny values, many flats
				default: begin
					// triangle wave with noise: well-formed peaks that get counted
					v = ((i + ph) % period) * 2 * amp / period;
					if (v > amp)
						v = 2 * amp - v;
					v = v - amp / 2 + int'($urandom_range(0, noise)) - noise / 2;
				end
			endcase
			v = $signed(24'(v));
			push_beat(v, i == n - 1);
		end
		windows_sent++;
	endfunction

	task automatic wait_idle();
		wait (pending_q.size() == 0 && !sample_valid && report_q.size() == 0);
		// a result still on its way out of the output register
		repeat (40) @(negedge clk);
	endtask

	task automatic write_rate(logic [RATE_Q8_W-1:0] v);
		@(negedge clk);
		cfg_data = v;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		rate_q8 = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	logic [RATE_Q8_W-1:0] rate_plan [$] = '{16'd1, 16'd65535, 16'd0, 16'd384, 16'd640,
		16'd128, 16'd256, 16'd896};

	initial begin
		int n;
		wait (arst_n);
		// directed: extremes, flat top, ties, single sample, thinning at the reset rate
		push_beat(0, 0); push_beat(8388607, 0); push_beat(-8388608, 0);
		push_beat(8388607, 0); push_beat(0, 1);
		push_beat(0, 0); push_beat(5, 0); push_beat(5, 0); push_beat(5, 0); push_beat(0, 1);
		push_beat(-8388608, 1);
		push_beat(0, 0); push_beat(9, 0); push_beat(0, 0); push_beat(9, 0);
		push_beat(0, 0); push_beat(9, 0); push_beat(-1, 1);
		push_beat(-5, 0); push_beat(-5, 1);
		windows_sent += 5;
		// window past capacity, last beat dropped but still closes it
		for (int i = 0; i < DEPTH + 6; i++)
			push_beat(((i % 200) < 100 ? i % 200 : 200 - i % 200) * 20000, i == DEPTH + 5);
		windows_sent++;
		wait_idle();

		for (int ph = 0; items_sent < ITEM_GOAL; ph++) begin
			if (ph < rate_plan.size())
				write_rate(rate_plan[ph]);
			else
				write_rate(RATE_Q8_W'($urandom_range(0, 5) == 0 ? $urandom
					: $urandom_range(1, 1500)));
			// long hold-off on the receiver during the second phase
			if (ph == 1)
				want_hold = 1'b1;
			for (int w = 0; w < 10; w++) begin
				n = $urandom_range(0, 4) == 0 ? $urandom_range(1, 8) : $urandom_range(9, 48);
				push_window(n, $urandom_range(0, 9) < 6 ? 2 : $urandom_range(0, 1));
			end
			wait_idle();
		end
		write_rate(RATE_Q8_RESET);
		push_window(30, 2);
		wait_idle();
		repeat (200) @(negedge clk);

		$display("%0d sample beats in %0d windows, %0d result beats checked, %0d mismatches",
			items_sent, windows_sent, reports_seen, mismatches);
		$display("rate register swept from 0 to 65535, overflow and flat-top windows included");
		if (mismatches == 0 && report_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
